// ----- rtl/ccdf_pkg.sv -----
// package for the clock and climate display framer
// holds item types, rail codes, segment tables and digit helpers; no dependencies
package ccdf_pkg;

  localparam int FRAME_BITS = 32;

  // rail codes
  localparam logic [1:0] RAIL_HOUR   = 2'd0;
  localparam logic [1:0] RAIL_MINUTE = 2'd1;
  localparam logic [1:0] RAIL_SIGN   = 2'd2;

  // config register indexes
  localparam logic CFG_TWELVE_HOUR = 1'b0;
  localparam logic CFG_CELSIUS     = 1'b1;

  localparam logic [15:0] BIT_COLON = 16'h0020;
  localparam logic [15:0] BIT_HI_A  = 16'h4000;
  localparam logic [15:0] BIT_HI_B  = 16'h8000;

  localparam logic [FRAME_BITS-1:0] RAIL2_BASE    = 32'h0038_0000;
  localparam logic [FRAME_BITS-1:0] RAIL2_MINUS   = 32'h0002_0000;
  localparam logic [FRAME_BITS-1:0] RAIL2_HUNDRED = 32'h0005_0000;

  // fahrenheit scale, 13108 / 2^16 is 1/5 exact below 16384
  localparam logic [13:0] RECIP_FIVE = 14'd13108;
  // 205 / 2^11 is 1/10 exact below 1024
  localparam logic [7:0]  RECIP_TEN  = 8'd205;

  // first front stage: values with tens digits split off
  typedef struct packed {
    logic [7:0] hour;
    logic [4:0] hour_tens;
    logic [7:0] minute;
    logic [4:0] minute_tens;
    logic [6:0] humidity;
    logic [4:0] humidity_tens;
    logic       colon_on;
    logic       is_afternoon;
    logic       weekday_alarm;
    logic       alarm_one_on;
    logic       alarm_two_on;
    logic       charging;
    logic [6:0] temp_mag;
    logic       temp_minus;
    logic       temp_hundred;
  } split_t;

  // classified refresh request, as queued for the back end
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame0;
    logic [FRAME_BITS-1:0] frame1;
    logic                  temp_minus;
    logic                  temp_hundred;
    logic                  charging;
  } refresh_t;

  function automatic logic [4:0] tens_of(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * {8'd0, RECIP_TEN};
    return p[15:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [7:0] v, input logic [4:0] t);
    logic [7:0] r;
    r = v - ({t, 3'b000} + {2'b00, t, 1'b0});
    return r[3:0];
  endfunction

  function automatic logic [15:0] seg_tens(input logic [4:0] d);
    logic [15:0] s;
    case (d)
      5'd0:    s = 16'h003F;
      5'd1:    s = 16'h0006;
      5'd2:    s = 16'h005B;
      5'd3:    s = 16'h004F;
      5'd4:    s = 16'h0066;
      5'd5:    s = 16'h006D;
      5'd6:    s = 16'h007C;
      5'd7:    s = 16'h0007;
      5'd8:    s = 16'h007F;
      5'd9:    s = 16'h006F;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] seg_ones(input logic [3:0] d);
    logic [15:0] s;
    case (d)
      4'd0:    s = 16'h1F80;
      4'd1:    s = 16'h0300;
      4'd2:    s = 16'h2D80;
      4'd3:    s = 16'h2780;
      4'd4:    s = 16'h3300;
      4'd5:    s = 16'h3680;
      4'd6:    s = 16'h3E00;
      4'd7:    s = 16'h0380;
      4'd8:    s = 16'h3F80;
      4'd9:    s = 16'h3380;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // hour tens: zero and anything above two stay blank
  function automatic logic [15:0] seg_hour_tens(input logic [4:0] d);
    logic [15:0] s;
    case (d)
      5'd1:    s = 16'h0006;
      5'd2:    s = 16'h005B;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ccdf_front.sv -----
// front end: accepts refresh requests and builds the segment words in two stages
// depends on ccdf_pkg
module ccdf_front import ccdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       twelve_hour_mode,
  input  logic       celsius_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] hour_value,
  input  logic [7:0] minute_value,
  input  logic       colon_on,
  input  logic [7:0] temperature_c,
  input  logic [6:0] humidity_pct,
  input  logic       is_afternoon,
  input  logic       weekday_alarm,
  input  logic       alarm_one_on,
  input  logic       alarm_two_on,
  input  logic       charging,
  output logic       out_valid,
  input  logic       out_ready,
  output refresh_t   out_item
);

  logic     s1_valid;
  split_t   s1;
  split_t   s1_next;
  logic     s1_ready;
  logic     s2_ready;
  refresh_t s2_next;

  // stage 1 temperature path
  logic [7:0]  t_abs;
  logic [10:0] t_times9;
  logic [24:0] t_prod;
  logic [7:0]  t_sel;
  logic [9:0]  t_signed;
  logic [8:0]  t_mag;
  logic [8:0]  t_sat;

  // stage 2 digits
  logic [3:0]  hour_ones;
  logic [3:0]  minute_ones;
  logic [3:0]  humidity_ones;
  logic [4:0]  temp_tens;
  logic [3:0]  temp_ones;
  logic [15:0] hi0, lo0, hi1, lo1;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    t_abs    = temperature_c[7] ? (~temperature_c + 8'd1) : temperature_c;
    t_times9 = {t_abs, 3'b000} + {3'b000, t_abs};
    t_prod   = {14'd0, t_times9} * {11'd0, RECIP_FIVE};
    // division truncates toward zero, so divide the magnitude
    t_sel    = celsius_mode ? t_abs : t_prod[23:16];
    t_signed = temperature_c[7] ? (10'd0 - {2'b00, t_sel}) : {2'b00, t_sel};
    if (!celsius_mode) begin
      t_signed = t_signed + 10'd32;
    end
    t_mag = t_signed[9] ? 9'(10'd0 - t_signed) : t_signed[8:0];
    t_sat = (t_mag > 9'd199) ? 9'd199 : t_mag;

    s1_next.hour          = hour_value;
    s1_next.hour_tens     = tens_of(hour_value);
    s1_next.minute        = minute_value;
    s1_next.minute_tens   = tens_of(minute_value);
    s1_next.humidity      = humidity_pct;
    s1_next.humidity_tens = tens_of({1'b0, humidity_pct});
    s1_next.colon_on      = colon_on;
    s1_next.is_afternoon  = is_afternoon;
    s1_next.weekday_alarm = weekday_alarm;
    s1_next.alarm_one_on  = alarm_one_on;
    s1_next.alarm_two_on  = alarm_two_on;
    s1_next.charging      = charging;
    s1_next.temp_minus    = t_signed[9];
    s1_next.temp_hundred  = t_sat > 9'd99;
    s1_next.temp_mag      = (t_sat > 9'd99) ? 7'(t_sat - 9'd100) : t_sat[6:0];
  end

  always_comb begin
    hour_ones     = ones_of(s1.hour, s1.hour_tens);
    minute_ones   = ones_of(s1.minute, s1.minute_tens);
    humidity_ones = ones_of({1'b0, s1.humidity}, s1.humidity_tens);
    temp_tens     = tens_of({1'b0, s1.temp_mag});
    temp_ones     = ones_of({1'b0, s1.temp_mag}, temp_tens);

    hi0 = BIT_HI_A | (s1.weekday_alarm ? BIT_HI_B : 16'h0000);
    if (s1.humidity <= 7'd99) begin
      hi0 = hi0 | seg_tens(s1.humidity_tens) | seg_ones(humidity_ones);
    end
    lo0 = s1.colon_on ? BIT_COLON : 16'h0000;
    if (twelve_hour_mode) begin
      lo0 = lo0 | (s1.is_afternoon ? BIT_HI_B : BIT_HI_A);
    end
    if (s1.hour <= 8'd99) begin
      lo0 = lo0 | seg_hour_tens(s1.hour_tens) | seg_ones(hour_ones);
    end

    hi1 = seg_tens(temp_tens) | seg_ones(temp_ones) | (celsius_mode ? BIT_HI_A : BIT_HI_B);
    lo1 = (s1.alarm_one_on ? BIT_HI_A : 16'h0000) | (s1.alarm_two_on ? BIT_HI_B : 16'h0000);
    if (s1.minute <= 8'd99) begin
      lo1 = lo1 | seg_tens(s1.minute_tens) | seg_ones(minute_ones);
    end

    s2_next.frame0       = {hi0, lo0};
    s2_next.frame1       = {hi1, lo1};
    s2_next.temp_minus   = s1.temp_minus;
    s2_next.temp_hundred = s1.temp_hundred;
    s2_next.charging     = s1.charging;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1 <= s1_next;
    end
    if (s2_ready) begin
      out_item <= s2_next;
    end
  end

endmodule

// ----- rtl/ccdf_queue.sv -----
// two-entry queue between front and back end
// depends on ccdf_pkg
module ccdf_queue import ccdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  refresh_t wr_item,
  output logic     rd_valid,
  input  logic     rd_pop,
  output refresh_t rd_item
);

  refresh_t   entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_item  = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= !wptr;
      end
      if (do_rd) begin
        rptr <= !rptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_item;
    end
  end

endmodule

// ----- rtl/ccdf_back.sv -----
// back end: walks the three rails of the queued request into the output register
// depends on ccdf_pkg
module ccdf_back import ccdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_pop,
  input  refresh_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_rail,
  output logic [FRAME_BITS-1:0] out_frame,
  output logic                  out_last,
  output logic                  out_charge
);

  logic [1:0]            rail;
  logic [1:0]            rail_next;
  logic                  load;
  logic [FRAME_BITS-1:0] frame_sel;

  assign load   = in_valid && (!out_valid || out_ready);
  assign in_pop = load && (rail == RAIL_SIGN);

  always_comb begin
    unique case (rail)
      RAIL_HOUR: begin
        frame_sel = in_item.frame0;
        rail_next = RAIL_MINUTE;
      end
      RAIL_MINUTE: begin
        frame_sel = in_item.frame1;
        rail_next = RAIL_SIGN;
      end
      default: begin
        frame_sel = RAIL2_BASE
                  | (in_item.temp_minus   ? RAIL2_MINUS   : '0)
                  | (in_item.temp_hundred ? RAIL2_HUNDRED : '0);
        rail_next = RAIL_HOUR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rail      <= RAIL_HOUR;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rail      <= rail_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rail   <= rail;
      out_frame  <= frame_sel;
      out_last   <= rail == RAIL_SIGN;
      out_charge <= in_item.charging;
    end
  end

endmodule

// ----- rtl/clock_climate_display_framer.sv -----
// top level of the clock and climate display framer
// depends on ccdf_pkg, ccdf_front, ccdf_queue, ccdf_back
//
//  port group   dir  handshake                        payload
//  s_axis       in   s_axis_tvalid / s_axis_tready    refresh request in s_axis_tdata
//  m_axis       out  m_axis_tvalid / m_axis_tready    frame, rail in tuser, tlast on rail 2
//  cfg          in   cfg_valid / cfg_ready            cfg_index, cfg_data
//
// each request gives three frames, one per cycle while m_axis_tready is high, so the back end
// pops a request only once its third frame is loaded; the rail counter in the back end sets that pace
// the first frame of a request passes two front stages, the queue and the output register
// rst is synchronous and clears all valid flags; twelve_hour_mode to 0, celsius_mode to 1
// front and back stall independently through the two-entry queue; cfg_ready is always high
module clock_climate_display_framer import ccdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hour_value[7:0], minute_value[15:8], colon_on[16], temperature_c[24:17],
  // humidity_pct[31:25], is_afternoon[32], weekday_alarm[33], alarm_one_on[34],
  // alarm_two_on[35], charging[36], zero fill [39:37]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // segment_frame[31:0], charge_led[32], zero fill [39:33]
  output logic [39:0] m_axis_tdata,
  // last_frame
  output logic        m_axis_tlast,
  // rail_select[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  logic                  twelve_hour_mode;
  logic                  celsius_mode;
  logic                  front_valid;
  logic                  front_ready;
  refresh_t              front_item;
  logic                  q_valid;
  logic                  q_pop;
  refresh_t              q_item;
  logic [FRAME_BITS-1:0] frame;
  logic                  charge_led;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      twelve_hour_mode <= 1'b0;
      celsius_mode     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TWELVE_HOUR: twelve_hour_mode <= cfg_data;
        CFG_CELSIUS:     celsius_mode     <= cfg_data;
        default:         twelve_hour_mode <= twelve_hour_mode;
      endcase
    end
  end

  ccdf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .twelve_hour_mode (twelve_hour_mode),
    .celsius_mode     (celsius_mode),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .hour_value       (s_axis_tdata[7:0]),
    .minute_value     (s_axis_tdata[15:8]),
    .colon_on         (s_axis_tdata[16]),
    .temperature_c    (s_axis_tdata[24:17]),
    .humidity_pct     (s_axis_tdata[31:25]),
    .is_afternoon     (s_axis_tdata[32]),
    .weekday_alarm    (s_axis_tdata[33]),
    .alarm_one_on     (s_axis_tdata[34]),
    .alarm_two_on     (s_axis_tdata[35]),
    .charging         (s_axis_tdata[36]),
    .out_valid        (front_valid),
    .out_ready        (front_ready),
    .out_item         (front_item)
  );

  ccdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  ccdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_pop     (q_pop),
    .in_item    (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_rail   (m_axis_tuser),
    .out_frame  (frame),
    .out_last   (m_axis_tlast),
    .out_charge (charge_led)
  );

  assign m_axis_tdata = {7'd0, charge_led, frame};

`ifndef SYNTHESIS
  // tlast marks exactly the rail 2 frame
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == RAIL_SIGN)))
    else $error("tlast does not match rail 2");

  // rails come out in order with none skipped
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == RAIL_HOUR)
    |=> (!m_axis_tvalid || m_axis_tuser == RAIL_MINUTE))
    else $error("rail 1 did not follow rail 0");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == RAIL_MINUTE)
    |=> (!m_axis_tvalid || m_axis_tuser == RAIL_SIGN))
    else $error("rail 2 did not follow rail 1");

  // rail 2 frame carries only the sign field with its base segments lit
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == RAIL_SIGN)
    |-> (m_axis_tdata[15:0] == 16'h0000 && m_axis_tdata[21:19] == 3'b111))
    else $error("bad rail 2 frame");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// testbench for clock_climate_display_framer: sends refresh requests, predicts the
// three rail frames of each one and checks every frame; depends on ccdf_pkg and the rtl
module tb import ccdf_pkg::*; ();

  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [7:0]        hour;
    logic [7:0]        minute;
    logic              colon_on;
    logic signed [7:0] temperature;
    logic [6:0]        humidity;
    logic              is_afternoon;
    logic              weekday_alarm;
    logic              alarm_one_on;
    logic              alarm_two_on;
    logic              charging;
  } refresh_req_t;

  typedef struct {
    logic [1:0]            rail;
    logic [FRAME_BITS-1:0] segments;
    logic                  last;
    logic                  charge_led;
  } rail_frame_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic        cfg_data;

  clock_climate_display_framer DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // seven-segment glyphs
  logic [15:0] ones_glyph [10] = '{16'h1F80, 16'h0300, 16'h2D80, 16'h2780, 16'h3300,
                                   16'h3680, 16'h3E00, 16'h0380, 16'h3F80, 16'h3380};
  logic [15:0] tens_glyph [10] = '{16'h003F, 16'h0006, 16'h005B, 16'h004F, 16'h0066,
                                   16'h006D, 16'h007C, 16'h0007, 16'h007F, 16'h006F};
  logic [15:0] hour_tens_glyph [3] = '{16'h0000, 16'h0006, 16'h005B};

  // display mode as last written
  logic twelve_hour_cfg;
  logic celsius_cfg;

  rail_frame_t expected_frames[$];
  int mismatch_count;
  int requests_sent;
  int frames_checked;
  int reg_writes;
  bit src_idle;
  bit sink_idle;
  int sink_hold;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] digit_pair(input int v);
    return tens_glyph[(v / 10) % 10] | ones_glyph[v % 10];
  endfunction

  task automatic predict_frames(input refresh_req_t r);
    logic [15:0] hi;
    logic [15:0] lo;
    logic [FRAME_BITS-1:0] sign_frame;
    rail_frame_t f;
    int t;
    int mag;
    int hour_tens;
    // rail 0: humidity above, hour below
    hi = BIT_HI_A | (r.weekday_alarm ? BIT_HI_B : 16'h0000);
    if (r.humidity <= 99) hi |= digit_pair(r.humidity);
    lo = r.colon_on ? BIT_COLON : 16'h0000;
    if (twelve_hour_cfg) lo |= r.is_afternoon ? BIT_HI_B : BIT_HI_A;
    if (r.hour <= 99) begin
      hour_tens = r.hour / 10;
      if (hour_tens <= 2) lo |= hour_tens_glyph[hour_tens];
      lo |= ones_glyph[r.hour % 10];
    end
    f.rail = RAIL_HOUR;
    f.segments = {hi, lo};
    f.last = 1'b0;
    f.charge_led = r.charging;
    expected_frames.push_back(f);
    // rail 1: temperature above, minute below
    t = r.temperature;
    if (!celsius_cfg) t = (t * 9) / 5 + 32;
    sign_frame = RAIL2_BASE;
    if (t < 0) begin
      sign_frame |= RAIL2_MINUS;
      mag = -t;
    end else begin
      mag = t;
    end
    if (mag > 199) mag = 199;
    if (mag > 99) begin
      sign_frame |= RAIL2_HUNDRED;
      mag -= 100;
    end
    hi = digit_pair(mag) | (celsius_cfg ? BIT_HI_A : BIT_HI_B);
    lo = (r.minute <= 99) ? digit_pair(r.minute) : 16'h0000;
    lo |= (r.alarm_one_on ? BIT_HI_A : 16'h0000) | (r.alarm_two_on ? BIT_HI_B : 16'h0000);
    f.rail = RAIL_MINUTE;
    f.segments = {hi, lo};
    expected_frames.push_back(f);
    // rail 2: minus sign and leading one
    f.rail = RAIL_SIGN;
    f.segments = sign_frame;
    f.last = 1'b1;
    expected_frames.push_back(f);
  endtask

  function automatic refresh_req_t make_req(input int hour, input int minute, input int colon,
                                            input int temp, input int hum,
                                            input logic [4:0] flags);
    refresh_req_t r;
    r.hour = 8'(hour);
    r.minute = 8'(minute);
    r.colon_on = colon[0];
    r.temperature = 8'(temp);
    r.humidity = 7'(hum);
    r.is_afternoon = flags[0];
    r.weekday_alarm = flags[1];
    r.alarm_one_on = flags[2];
    r.alarm_two_on = flags[3];
    r.charging = flags[4];
    return r;
  endfunction

  // mostly clock-like values, the rest over the whole field range
  function automatic refresh_req_t random_req();
    refresh_req_t r;
    if ($urandom_range(0, 3) != 0) begin
      r = make_req($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 1),
                   int'($urandom_range(0, 198)) - 99, $urandom_range(0, 99),
                   5'($urandom));
    end else begin
      r = make_req($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                   int'($urandom_range(0, 255)) - 128, $urandom_range(0, 127),
                   5'($urandom));
    end
    return r;
  endfunction

  task automatic send_request(input refresh_req_t r);
    int gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, r.charging, r.alarm_two_on, r.alarm_one_on, r.weekday_alarm,
                     r.is_afternoon, r.humidity, r.temperature, r.colon_on, r.minute, r.hour};
    @(posedge clk);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
    predict_frames(r);
    requests_sent++;
  endtask

  // stop offering and let every pending frame come out
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    if (idx == CFG_TWELVE_HOUR) twelve_hour_cfg = val;
    else if (idx == CFG_CELSIUS) celsius_cfg = val;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input logic twelve, input logic celsius);
    drain();
    write_register(CFG_TWELVE_HOUR, twelve);
    write_register(CFG_CELSIUS, celsius);
  endtask

  // reset modes: 24 hour, celsius; digit blanking and sign edges
  task automatic test_digit_edges();
    send_request(make_req(0, 0, 0, 0, 0, 5'b00000));
    send_request(make_req(9, 9, 1, -1, 9, 5'b11111));
    send_request(make_req(12, 34, 1, 25, 56, 5'b10101));
    send_request(make_req(19, 59, 0, -99, 99, 5'b01010));
    send_request(make_req(20, 99, 1, 99, 100, 5'b00110));
    send_request(make_req(29, 100, 0, 127, 127, 5'b11001));
    send_request(make_req(30, 255, 1, -128, 64, 5'b10000));
    send_request(make_req(99, 0, 0, -100, 100, 5'b01100));
    send_request(make_req(100, 10, 1, 100, 37, 5'b00011));
    send_request(make_req(255, 45, 0, -50, 0, 5'b11110));
    send_request(make_req(10, 5, 1, 101, 88, 5'b00001));
  endtask

  // 12 hour and fahrenheit: am/pm, truncation toward zero, saturation
  task automatic test_fahrenheit_ampm();
    set_mode(1'b1, 1'b0);
    send_request(make_req(11, 30, 1, -128, 45, 5'b00000));
    send_request(make_req(12, 0, 1, -40, 45, 5'b00001));
    send_request(make_req(1, 15, 0, -18, 20, 5'b10001));
    send_request(make_req(7, 7, 1, -21, 70, 5'b00000));
    send_request(make_req(8, 8, 0, 38, 12, 5'b11111));
    send_request(make_req(3, 3, 1, 93, 33, 5'b00101));
    send_request(make_req(4, 4, 0, 94, 44, 5'b01000));
    send_request(make_req(5, 5, 1, 127, 55, 5'b00001));
    send_request(make_req(6, 6, 0, 0, 66, 5'b10000));
  endtask

  // random requests over all four display modes
  task automatic test_random_modes();
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0], phase[1]);
      // one phase runs without any idling
      src_idle = (phase != 2);
      sink_idle = (phase != 2);
      for (int i = 0; i < 20; i++) send_request(random_req());
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    src_idle = 1'b0;
    sink_hold = 80;
    for (int i = 0; i < 12; i++) send_request(random_req());
    src_idle = 1'b1;
  endtask

  initial begin : frame_sink
    int gap;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      gap = sink_idle ? $urandom_range(0, 14) : 0;
      if (sink_hold != 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : frame_check
    rail_frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      frames_checked++;
      if (expected_frames.size() == 0) begin
        $error("frame with nothing pending: rail %0d, segments %h", m_axis_tuser,
               m_axis_tdata[31:0]);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (m_axis_tuser !== want.rail) begin
          $error("rail_select: expected %0d, got %0d", want.rail, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[31:0] !== want.segments) begin
          $error("segment_frame: expected %h, got %h", want.segments, m_axis_tdata[31:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_frame: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[32] !== want.charge_led) begin
          $error("charge_led: expected %0d, got %0d", want.charge_led, m_axis_tdata[32]);
          mismatch_count++;
        end
      end
    end
  end

  // ends the run when no transaction of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    twelve_hour_cfg = 1'b0;
    celsius_cfg = 1'b1;
    mismatch_count = 0;
    requests_sent = 0;
    frames_checked = 0;
    reg_writes = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    sink_hold = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_digit_edges();
    test_fahrenheit_ampm();
    test_random_modes();
    test_output_stall();
    drain();
    repeat (10) @(posedge clk);

    $display("%0d refresh requests, %0d frames checked, %0d register writes",
             requests_sent, frames_checked, reg_writes);
    $display("covered blanking, fahrenheit and sign edges, all display modes, output stall");
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
